@@ rtl/csls_pkg.sv @@
// shared constants, types and helpers for the c source listing scanner
// no dependencies
`default_nettype none

package csls_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CNT_OUT_W  = 16;
  localparam int BYTE_W     = 8;
  localparam int REP_W      = 4;
  localparam int LEN_W      = BYTE_W + 1;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TAB_WIDTH      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WRAP_COLUMN    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LINES_PER_PAGE = 2'd2;

  localparam logic [3:0] TAB_WIDTH_RST      = 4'd3;
  localparam logic [7:0] WRAP_COLUMN_RST    = 8'd74;
  localparam logic [7:0] LINES_PER_PAGE_RST = 8'd58;
  localparam logic [3:0] TAB_MAX            = 4'd8;
  localparam logic [7:0] PAGE_LINE_MAX      = 8'd255;
  localparam logic [7:0] PAGE_LINE_RST      = 8'd1;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  localparam logic signed [COUNT_BITS-1:0] SMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] SMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0]        UMAX = {COUNT_BITS{1'b1}};

  // pending results of one accepted byte
  typedef struct packed {
    logic [BYTE_W-1:0]           rep_byte;
    logic [REP_W-1:0]            rep_cnt;
    logic                        tail_nl;
    logic                        page_brk;
    logic signed [CNT_OUT_W-1:0] nest;
    logic [CNT_OUT_W-1:0]        lines;
    logic [CNT_OUT_W-1:0]        stmts;
    logic                        bal;
  } job_t;

  function automatic logic signed [COUNT_BITS-1:0] sat_up(
    input logic signed [COUNT_BITS-1:0] v
  );
    sat_up = (v == SMAX) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic signed [COUNT_BITS-1:0] sat_down(
    input logic signed [COUNT_BITS-1:0] v
  );
    sat_down = (v == SMIN) ? v : v - COUNT_BITS'(1);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == UMAX) ? v : v + COUNT_BITS'(1);
  endfunction

endpackage

`default_nettype wire

@@ rtl/c_source_listing_scanner.sv @@
// c source listing scanner top level: lexical state, counters and listing output
// depends on csls_pkg
`default_nettype none

// Each source byte is taken with its lookahead byte and turned into one to nine
// listing bytes; a byte of zero is consumed and yields nothing. The pending job
// feeds the single result register one listing byte per cycle while out_tready
// holds, so non-wrapping ordinary bytes stream at one per cycle; a tab or a
// wrapping byte holds the input until all its listing bytes are sent. Every
// result carries the counters as they stand after the byte that caused it.
// Configuration must be written only while idle; the block does not enforce it.
module c_source_listing_scanner (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire [csls_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire [csls_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // src_byte[7:0], next_byte[15:8]
  input  wire [csls_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // out_byte[7:0], nest_level[23:8], line_count[39:24], statement_count[55:40],
  // balanced[56], zero fill above
  output logic [csls_pkg::OUT_DATA_W-1:0] out_tdata,
  // line_end[0], page_start[1]
  output logic [csls_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                            out_tlast
);

  logic [3:0] tab_width_r;
  logic [7:0] wrap_column_r;
  logic [7:0] lines_per_page_r;

  logic in_comment_r, in_comment_nxt;
  logic in_squote_r, in_squote_nxt;
  logic in_dquote_r, in_dquote_nxt;
  logic signed [csls_pkg::COUNT_BITS-1:0] brace_r, brace_nxt;
  logic signed [csls_pkg::COUNT_BITS-1:0] bracket_r, bracket_nxt;
  logic signed [csls_pkg::COUNT_BITS-1:0] paren_r, paren_nxt;
  logic [csls_pkg::COUNT_BITS-1:0] semis_r, semis_nxt;
  logic [csls_pkg::COUNT_BITS-1:0] lines_r, lines_nxt;
  logic [7:0] column_r, column_nxt;
  logic [7:0] page_line_r, page_line_nxt;
  logic [7:0] prior_r, prior_prior_r;

  csls_pkg::job_t job_r, job_nxt;
  logic           job_valid_r, job_valid_nxt;

  logic [7:0] out_byte_r;
  logic       out_le_r, out_ps_r, out_last_r;
  logic signed [csls_pkg::CNT_OUT_W-1:0] out_nest_r;
  logic [csls_pkg::CNT_OUT_W-1:0] out_lines_r, out_stmts_r;
  logic       out_bal_r;
  logic       out_valid_r;

  logic [7:0] c, nx;
  logic       in_fire, live;
  logic       out_can_load, emit, emit_last;
  logic [3:0] tw;
  logic [csls_pkg::LEN_W-1:0] len;
  logic       wrap, ps;

  assign c  = in_tdata[7:0];
  assign nx = in_tdata[15:8];

  assign out_can_load = !out_valid_r || out_tready;
  assign emit         = job_valid_r && out_can_load;
  // rep_cnt of zero only happens with the newline still pending
  assign emit_last    = (job_r.rep_cnt == '0) ||
                        (job_r.rep_cnt == 4'd1 && !job_r.tail_nl);
  assign in_tready    = !job_valid_r || (emit && emit_last);
  assign in_fire      = in_tvalid && in_tready;
  assign live         = in_fire && (c != csls_pkg::CH_NUL);

  // tab width clamped to one through eight
  always_comb begin
    if (tab_width_r == 4'd0) begin
      tw = 4'd1;
    end else if (tab_width_r > csls_pkg::TAB_MAX) begin
      tw = csls_pkg::TAB_MAX;
    end else begin
      tw = tab_width_r;
    end
  end

  always_comb begin
    if (c == csls_pkg::CH_TAB) begin
      len = {1'b0, column_r} + {{(csls_pkg::LEN_W-4){1'b0}}, tw};
    end else begin
      len = {1'b0, column_r} + csls_pkg::LEN_W'(1);
    end
    wrap = (len > {1'b0, wrap_column_r}) || (c == csls_pkg::CH_LF);
    ps   = page_line_r > lines_per_page_r;
  end

  // lexical state and counters
  always_comb begin
    in_comment_nxt = in_comment_r;
    in_squote_nxt  = in_squote_r;
    in_dquote_nxt  = in_dquote_r;
    brace_nxt      = brace_r;
    bracket_nxt    = bracket_r;
    paren_nxt      = paren_r;
    semis_nxt      = semis_r;
    lines_nxt      = lines_r;
    if (c == csls_pkg::CH_LF) begin
      lines_nxt = csls_pkg::sat_inc(lines_r);
    end
    if (!in_comment_r && !in_squote_r && !in_dquote_r) begin
      case (c)
        csls_pkg::CH_LBRACE: brace_nxt     = csls_pkg::sat_up(brace_r);
        csls_pkg::CH_RBRACE: brace_nxt     = csls_pkg::sat_down(brace_r);
        csls_pkg::CH_LPAREN: paren_nxt     = csls_pkg::sat_up(paren_r);
        csls_pkg::CH_RPAREN: paren_nxt     = csls_pkg::sat_down(paren_r);
        csls_pkg::CH_LBRACK: bracket_nxt   = csls_pkg::sat_up(bracket_r);
        csls_pkg::CH_RBRACK: bracket_nxt   = csls_pkg::sat_down(bracket_r);
        csls_pkg::CH_SLASH:  in_comment_nxt = (nx == csls_pkg::CH_STAR);
        csls_pkg::CH_SEMI:   semis_nxt     = csls_pkg::sat_inc(semis_r);
        csls_pkg::CH_SQUOTE: in_squote_nxt = 1'b1;
        csls_pkg::CH_DQUOTE: in_dquote_nxt = 1'b1;
        default: begin
        end
      endcase
    end else begin
      if (in_comment_r && c == csls_pkg::CH_STAR && nx == csls_pkg::CH_SLASH) begin
        in_comment_nxt = 1'b0;
      end
      // escaped quote unless the backslash is itself escaped
      if (in_squote_r && c == csls_pkg::CH_SQUOTE &&
          (prior_r != csls_pkg::CH_BSLASH || prior_prior_r == csls_pkg::CH_BSLASH)) begin
        in_squote_nxt = 1'b0;
      end
      if (in_dquote_r && c == csls_pkg::CH_DQUOTE) begin
        in_dquote_nxt = 1'b0;
      end
    end

    if (wrap) begin
      column_nxt = '0;
      if (ps) begin
        page_line_nxt = csls_pkg::PAGE_LINE_RST;
      end else if (page_line_r < csls_pkg::PAGE_LINE_MAX) begin
        page_line_nxt = page_line_r + 8'd1;
      end else begin
        page_line_nxt = page_line_r;
      end
    end else begin
      column_nxt    = len[7:0];
      page_line_nxt = page_line_r;
    end
  end

  // job register
  always_comb begin
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    if (emit) begin
      if (emit_last) begin
        job_valid_nxt = 1'b0;
      end else if (job_r.rep_cnt != '0) begin
        job_nxt.rep_cnt = job_r.rep_cnt - 4'd1;
      end
    end
    if (live) begin
      job_valid_nxt    = 1'b1;
      job_nxt.tail_nl  = wrap;
      job_nxt.page_brk = ps;
      if (c == csls_pkg::CH_TAB) begin
        job_nxt.rep_byte = csls_pkg::CH_SPACE;
        job_nxt.rep_cnt  = tw;
      end else if (c == csls_pkg::CH_LF) begin
        job_nxt.rep_byte = c;
        job_nxt.rep_cnt  = '0;
      end else begin
        job_nxt.rep_byte = c;
        job_nxt.rep_cnt  = 4'd1;
      end
      job_nxt.nest  = csls_pkg::CNT_OUT_W'(brace_nxt);
      job_nxt.lines = csls_pkg::CNT_OUT_W'(lines_nxt);
      job_nxt.stmts = csls_pkg::CNT_OUT_W'(semis_nxt);
      job_nxt.bal   = (brace_nxt == '0) && (bracket_nxt == '0) && (paren_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_width_r      <= csls_pkg::TAB_WIDTH_RST;
      wrap_column_r    <= csls_pkg::WRAP_COLUMN_RST;
      lines_per_page_r <= csls_pkg::LINES_PER_PAGE_RST;
      in_comment_r     <= 1'b0;
      in_squote_r      <= 1'b0;
      in_dquote_r      <= 1'b0;
      brace_r          <= '0;
      bracket_r        <= '0;
      paren_r          <= '0;
      semis_r          <= '0;
      lines_r          <= '0;
      column_r         <= '0;
      page_line_r      <= csls_pkg::PAGE_LINE_RST;
      prior_r          <= '0;
      prior_prior_r    <= '0;
      job_valid_r      <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          csls_pkg::REG_TAB_WIDTH:      tab_width_r      <= cfg_wdata[3:0];
          csls_pkg::REG_WRAP_COLUMN:    wrap_column_r    <= cfg_wdata;
          csls_pkg::REG_LINES_PER_PAGE: lines_per_page_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (live) begin
        in_comment_r  <= in_comment_nxt;
        in_squote_r   <= in_squote_nxt;
        in_dquote_r   <= in_dquote_nxt;
        brace_r       <= brace_nxt;
        bracket_r     <= bracket_nxt;
        paren_r       <= paren_nxt;
        semis_r       <= semis_nxt;
        lines_r       <= lines_nxt;
        column_r      <= column_nxt;
        page_line_r   <= page_line_nxt;
        prior_prior_r <= prior_r;
        prior_r       <= c;
      end
      job_valid_r <= job_valid_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (emit) begin
      if (job_r.rep_cnt != '0) begin
        out_byte_r <= job_r.rep_byte;
        out_le_r   <= 1'b0;
        out_ps_r   <= 1'b0;
      end else begin
        out_byte_r <= csls_pkg::CH_LF;
        out_le_r   <= 1'b1;
        out_ps_r   <= job_r.page_brk;
      end
      out_last_r  <= emit_last;
      out_nest_r  <= job_r.nest;
      out_lines_r <= job_r.lines;
      out_stmts_r <= job_r.stmts;
      out_bal_r   <= job_r.bal;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ps_r, out_le_r};
  assign out_tdata  = {7'd0, out_bal_r, out_stmts_r, out_lines_r, out_nest_r, out_byte_r};

  // checks
  a_rep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> (job_r.rep_cnt <= csls_pkg::TAB_MAX))
    else $error("job repeat count beyond tab maximum");

  a_page_on_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ps_r) |-> (out_le_r && out_last_r))
    else $error("page start without final line end");

  a_line_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_le_r) |-> (out_byte_r == csls_pkg::CH_LF))
    else $error("line end flag on a byte other than newline");

  a_job_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    live |=> job_valid_r)
    else $error("accepted byte left no pending job");

endmodule

`default_nettype wire
